// File: sv/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

  // Field widths
  localparam int SIZE_W  = 24;
  localparam int LEVEL_W = 6;
  localparam int BOUND_W = 17;
  localparam int LEN_W   = 2;

  // Quantizer constants
  localparam int NUM_BOUNDS = 61;
  localparam logic [SIZE_W-1:0]  SIZE_SATURATE = 24'd150000;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO    = 6'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 6'd63;

  // Report length codes
  localparam logic [LEN_W-1:0] LEN_LONG  = 2'd3;
  localparam logic [LEN_W-1:0] LEN_SHORT = 2'd1;

  // Increasing level thresholds; for a nonzero unsaturated size, level is one plus the first index above the size
  localparam logic [BOUND_W-1:0] LEVEL_BOUNDS [0:NUM_BOUNDS-1] = '{
    17'd10, 17'd12, 17'd14, 17'd17, 17'd19, 17'd22, 17'd26, 17'd31, 17'd36,
    17'd42, 17'd49, 17'd57, 17'd67, 17'd78, 17'd91, 17'd107, 17'd125,
    17'd146, 17'd171, 17'd200, 17'd234, 17'd274, 17'd321, 17'd376, 17'd440,
    17'd515, 17'd603, 17'd706, 17'd826, 17'd967, 17'd1132, 17'd1326,
    17'd1552, 17'd1817, 17'd2127, 17'd2490, 17'd2915, 17'd3413, 17'd3995,
    17'd4667, 17'd5476, 17'd6411, 17'd7505, 17'd8787, 17'd10287, 17'd12043,
    17'd14099, 17'd16507, 17'd19325, 17'd22624, 17'd26487, 17'd31009,
    17'd36304, 17'd42502, 17'd49759, 17'd58255, 17'd68201, 17'd79846,
    17'd93479, 17'd109439, 17'd128125
  };

  // One finished report
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [7:0]       byte2;
    logic [7:0]       byte1;
    logic [7:0]       byte0;
  } report_t;

  // Quantized view of the four groups
  typedef struct packed {
    logic [3:0]               nonzero;
    logic [3:0][LEVEL_W-1:0]  level;
    logic                     long_format;
  } levels_t;

endpackage

`default_nettype wire

// File: sv/bsr_buffer_status_encoder.sv
// Buffer status report encoder.
// Path from an accepted request to its report on the master side
//   (input register, then quantizer comparator bank and packing into the result register).
// Throughput: 1 report per cycle unless m_tready stalls; stages move as the next drains.
// Reset: synchronous, clears both stage valid flags; payload registers are not reset.
`default_nettype none

module bsr_buffer_status_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // size_group0, size_group1, size_group2, size_group3
  input  wire logic        s_tuser,   // long_format
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // report_byte0, report_byte1, report_byte2,
                                      // report_length, zero fill
);

  logic        in_valid;
  logic [95:0] in_sizes;
  logic        in_long;

  logic             out_valid;
  bsr_pkg::report_t out_report;

  logic             out_load;
  logic             in_load;
  bsr_pkg::levels_t lv;
  bsr_pkg::report_t report_next;

  // Stage handshake: each register takes new data when empty or draining
  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (in_load) begin
      in_sizes <= s_tdata;
      in_long  <= s_tuser;
    end
  end

  // Quantize each group
  for (genvar g = 0; g < 4; g++) begin : g_group
    bsr_quantizer u_quant (
      .size  (in_sizes[g*bsr_pkg::SIZE_W +: bsr_pkg::SIZE_W]),
      .level (lv.level[g])
    );
    assign lv.nonzero[g] = (in_sizes[g*bsr_pkg::SIZE_W +: bsr_pkg::SIZE_W] != '0);
  end
  assign lv.long_format = in_long;

  bsr_packer u_pack (
    .lv     (lv),
    .report (report_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (out_load && in_valid) begin
      out_report <= report_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_report};

endmodule

`default_nettype wire

// File: sv/bsr_quantizer.sv
`default_nettype none

module bsr_quantizer (
  input  wire logic [bsr_pkg::SIZE_W-1:0]  size,
  output logic      [bsr_pkg::LEVEL_W-1:0] level
);

  // Parallel compare against the table; the lowest threshold above the size wins
  always_comb begin
    logic [bsr_pkg::LEVEL_W-1:0] first_above;
    first_above = 6'(bsr_pkg::NUM_BOUNDS);
    for (int k = bsr_pkg::NUM_BOUNDS - 1; k >= 0; k--) begin
      if (size < {{(bsr_pkg::SIZE_W-bsr_pkg::BOUND_W){1'b0}},
                  bsr_pkg::LEVEL_BOUNDS[k]}) begin
        first_above = 6'(k);
      end
    end
    if (size == '0) begin
      level = bsr_pkg::LEVEL_ZERO;
    end else if (size > bsr_pkg::SIZE_SATURATE) begin
      level = bsr_pkg::LEVEL_MAX;
    end else begin
      level = first_above + 6'd1;
    end
  end

endmodule

`default_nettype wire

// File: sv/bsr_packer.sv
`default_nettype none

module bsr_packer (
  input  wire bsr_pkg::levels_t lv,
  output bsr_pkg::report_t      report
);

  always_comb begin
    logic [1:0]                  top;
    logic [bsr_pkg::LEVEL_W-1:0] top_level;
    // highest nonzero group, group 0 when all are empty
    top = 2'd0;
    for (int g = 1; g < 4; g++) begin
      if (lv.nonzero[g]) begin
        top = 2'(g);
      end
    end
    top_level = lv.level[top];

    if (lv.long_format) begin
      report.byte0  = {lv.level[0], lv.level[1][5:4]};
      report.byte1  = {lv.level[1][3:0], lv.level[2][5:2]};
      report.byte2  = {lv.level[2][1:0], lv.level[3]};
      report.length = bsr_pkg::LEN_LONG;
    end else begin
      report.byte0  = {top, top_level};
      report.byte1  = 8'd0;
      report.byte2  = 8'd0;
      report.length = bsr_pkg::LEN_SHORT;
    end
  end

endmodule

`default_nettype wire

// File: sv/bsr_checker.sv
`default_nettype none

module bsr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [95:0] s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // A stalled report holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("report changed while stalled");

  // No report right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("report valid after reset");

  // Length is one of the two codes
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[25:24] == bsr_pkg::LEN_LONG) ||
                 (m_tdata[25:24] == bsr_pkg::LEN_SHORT))
    else $error("bad report length");

  // Short report leaves the unused octets clear
  a_short: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[25:24] == bsr_pkg::LEN_SHORT) |-> m_tdata[23:8] == 16'd0)
    else $error("short report with nonzero trailing octets");

  // A request accepted on an idle pipe appears after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid && m_tready |=> ##1 m_tvalid)
    else $error("report missing after request");

endmodule

bind bsr_buffer_status_encoder bsr_checker u_bsr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
